[rtl/sha1md_pkg.sv]
// Shared types, constants and helpers of the SHA-1 message digest block.
// No dependencies; used by sha1md_round, the top level and the testbench.
package sha1md_pkg;

  localparam int WordW      = 32;
  localparam int ChainDepth = 5;
  localparam int ChainAddrW = 3;
  localparam int CountW     = 61;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // Working variables a..e of one compression.
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    logic [WordW-1:0] e;
  } wvars_t;

  // Initial chaining value h0..h4.
  function automatic logic [WordW-1:0] init_word(input logic [ChainAddrW-1:0] idx);
    logic [WordW-1:0] val;
    unique case (idx)
      3'd0:    val = 32'h67452301;
      3'd1:    val = 32'hEFCDAB89;
      3'd2:    val = 32'h98BADCFE;
      3'd3:    val = 32'h10325476;
      3'd4:    val = 32'hC3D2E1F0;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[rtl/sha1md_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sha1md_ram #(
  parameter int Width = 32,
  parameter int Depth = 5,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data_r
);

  logic [Width-1:0] mem_r [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule

[rtl/sha1md_round.sv]
// One SHA-1 round: round function, constant, new a..e and the next schedule word.
// Depends on sha1md_pkg.
module sha1md_round (
  input  logic [6:0]                    round_idx,
  input  sha1md_pkg::wvars_t            vars,
  input  logic [sha1md_pkg::WordW-1:0]  w0,
  input  logic [sha1md_pkg::WordW-1:0]  w2,
  input  logic [sha1md_pkg::WordW-1:0]  w8,
  input  logic [sha1md_pkg::WordW-1:0]  w13,
  output sha1md_pkg::wvars_t            next_vars,
  output logic [sha1md_pkg::WordW-1:0]  w_new
);

  logic [sha1md_pkg::WordW-1:0] f;
  logic [sha1md_pkg::WordW-1:0] k;
  logic [sha1md_pkg::WordW-1:0] mix;
  logic [sha1md_pkg::WordW-1:0] t;

  always_comb begin
    if (round_idx < 7'd20) begin
      f = (vars.b & vars.c) | (~vars.b & vars.d);
      k = sha1md_pkg::K0;
    end else if (round_idx < 7'd40) begin
      f = vars.b ^ vars.c ^ vars.d;
      k = sha1md_pkg::K1;
    end else if (round_idx < 7'd60) begin
      f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
      k = sha1md_pkg::K2;
    end else begin
      f = vars.b ^ vars.c ^ vars.d;
      k = sha1md_pkg::K3;
    end
    t = {vars.a[26:0], vars.a[31:27]} + f + vars.e + k + w0;
    next_vars.a = t;
    next_vars.b = vars.a;
    next_vars.c = {vars.b[1:0], vars.b[31:2]};
    next_vars.d = vars.c;
    next_vars.e = vars.d;
    // The window always holds the next sixteen schedule words, so the word
    // sixteen rounds ahead comes from fixed taps.
    mix   = w13 ^ w8 ^ w2 ^ w0;
    w_new = {mix[30:0], mix[31]};
  end

endmodule

[rtl/sha1_message_digest.sv]
// Top level of the SHA-1 message digest: byte packing, padding sequencer,
// compression control and the chaining-value RAM. Depends on sha1md_pkg,
// sha1md_ram and sha1md_round.
//
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | data_byte, carries_byte, end_of_message
// out_    | output    | out_valid/out_stall | digest_word, word_index, last_word
//
// A data word is taken while in_stall is low; the 64th byte of a block starts
// a compression (chain loads, 80 rounds at one per cycle, write-back). End of
// message feeds padding at one byte per cycle between compressions, with one or
// two compressions; then each digest word is read from the RAM and held until
// taken. Reset is synchronous; the chaining value reads as the initial constants
// until the first write-back. No input is taken while the digest is out.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_carries_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PAD    = 4'd1;
  localparam logic [3:0] S_FILL   = 4'd2;
  localparam logic [3:0] S_LEN    = 4'd3;
  localparam logic [3:0] S_LOAD   = 4'd4;
  localparam logic [3:0] S_ROUND  = 4'd5;
  localparam logic [3:0] S_WB     = 4'd6;
  localparam logic [3:0] S_OUT_RD = 4'd7;
  localparam logic [3:0] S_OUT_LD = 4'd8;
  localparam logic [3:0] S_OUT_WT = 4'd9;

  localparam int AW = sha1md_pkg::ChainAddrW;
  localparam int WW = sha1md_pkg::WordW;

  logic [3:0]                    state_r;
  logic [3:0]                    ret_r;
  logic [5:0]                    pos_r;
  logic [sha1md_pkg::CountW-1:0] count_r;
  logic [23:0]                   acc_r;
  logic [WW-1:0]                 window_r [16];
  sha1md_pkg::wvars_t            wv_r;
  logic [2:0]                    cnt_r;
  logic [6:0]                    round_r;
  logic [2:0]                    len_idx_r;
  logic [AW-1:0]                 oidx_r;
  logic                          fresh_r;
  logic [AW-1:0]                 rd_addr_q_r;
  logic                          out_valid_r;
  logic [WW-1:0]                 out_word_r;

  logic                          push_en;
  logic [7:0]                    push_byte;
  logic [3:0]                    push_cont;
  logic [63:0]                   bit_len;
  logic [AW-1:0]                 rd_addr;
  logic [WW-1:0]                 ram_rd;
  logic [WW-1:0]                 chain_rd;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [WW-1:0]                 wr_data;
  logic [WW-1:0]                 wv_pick;
  sha1md_pkg::wvars_t            round_vars;
  logic [WW-1:0]                 round_w;

  assign bit_len = {count_r, 3'b000};

  // Byte source for the packer: message data, pad marker, zero fill or length.
  always_comb begin
    push_en   = 1'b0;
    push_byte = '0;
    push_cont = S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_carries_byte) begin
          push_en   = 1'b1;
          push_byte = in_data_byte;
          push_cont = in_end_of_message ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        push_en   = 1'b1;
        push_byte = sha1md_pkg::PadByte;
        push_cont = S_FILL;
      end
      S_FILL: begin
        if (pos_r != 6'd56) begin
          push_en   = 1'b1;
          push_cont = S_FILL;
        end
      end
      S_LEN: begin
        push_en   = 1'b1;
        push_byte = bit_len[{len_idx_r, 3'b000} +: 8];
        push_cont = (len_idx_r == 3'd0) ? S_OUT_RD : S_LEN;
      end
      default: ;
    endcase
  end

  // Chain RAM read address: loads and write-back walk the entries, output
  // reads the word being sent.
  always_comb begin
    rd_addr = '0;
    if ((state_r == S_LOAD || state_r == S_WB) && cnt_r < 3'd5) begin
      rd_addr = cnt_r;
    end else if (state_r == S_OUT_RD) begin
      rd_addr = oidx_r;
    end
  end

  assign chain_rd = fresh_r ? sha1md_pkg::init_word(rd_addr_q_r) : ram_rd;

  always_comb begin
    case (cnt_r - 3'd1)
      3'd0:    wv_pick = wv_r.a;
      3'd1:    wv_pick = wv_r.b;
      3'd2:    wv_pick = wv_r.c;
      3'd3:    wv_pick = wv_r.d;
      default: wv_pick = wv_r.e;
    endcase
  end

  assign wr_en   = (state_r == S_WB) && (cnt_r != 3'd0);
  assign wr_addr = cnt_r - 3'd1;
  assign wr_data = chain_rd + wv_pick;

  sha1md_ram #(
    .Width(sha1md_pkg::WordW),
    .Depth(sha1md_pkg::ChainDepth)
  ) u_chain_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data_r(ram_rd)
  );

  sha1md_round u_round (
    .round_idx(round_r),
    .vars     (wv_r),
    .w0       (window_r[0]),
    .w2       (window_r[2]),
    .w8       (window_r[8]),
    .w13      (window_r[13]),
    .next_vars(round_vars),
    .w_new    (round_w)
  );

  always_ff @(posedge clk) begin
    rd_addr_q_r <= rd_addr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      pos_r       <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
      round_r     <= '0;
      len_idx_r   <= 3'd7;
      oidx_r      <= '0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
      wv_r        <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_carries_byte) begin
            count_r <= count_r + 1'b1;
          end else if (in_valid && in_end_of_message) begin
            state_r <= S_PAD;
          end
        end
        S_PAD: ;
        S_FILL: begin
          if (pos_r == 6'd56) begin
            state_r   <= S_LEN;
            len_idx_r <= 3'd7;
          end
        end
        S_LEN: begin
          len_idx_r <= len_idx_r - 3'd1;
        end
        S_LOAD: begin
          cnt_r <= cnt_r + 3'd1;
          case (cnt_r)
            3'd1:    wv_r.a <= chain_rd;
            3'd2:    wv_r.b <= chain_rd;
            3'd3:    wv_r.c <= chain_rd;
            3'd4:    wv_r.d <= chain_rd;
            3'd5:    wv_r.e <= chain_rd;
            default: ;
          endcase
          if (cnt_r == 3'd5) begin
            state_r <= S_ROUND;
            round_r <= '0;
          end
        end
        S_ROUND: begin
          wv_r <= round_vars;
          for (int i = 0; i < 15; i++) begin
            window_r[i] <= window_r[i+1];
          end
          window_r[15] <= round_w;
          if (round_r == 7'd79) begin
            state_r <= S_WB;
            cnt_r   <= '0;
            round_r <= '0;
          end else begin
            round_r <= round_r + 7'd1;
          end
        end
        S_WB: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd5) begin
            fresh_r <= 1'b0;
            state_r <= ret_r;
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_word_r  <= chain_rd;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT_WT;
        end
        S_OUT_WT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (oidx_r == 3'd4) begin
              oidx_r  <= '0;
              count_r <= '0;
              fresh_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              oidx_r  <= oidx_r + 3'd1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Pack the byte; a completed word enters the schedule window, and the
      // last byte of a block starts a compression that resumes at push_cont.
      if (push_en) begin
        pos_r <= pos_r + 6'd1;
        if (pos_r[1:0] == 2'd3) begin
          for (int i = 0; i < 15; i++) begin
            window_r[i] <= window_r[i+1];
          end
          window_r[15] <= {acc_r, push_byte};
        end else begin
          acc_r <= {acc_r[15:0], push_byte};
        end
        ret_r <= push_cont;
        cnt_r <= '0;
        state_r <= (pos_r == 6'd63) ? S_LOAD : push_cont;
      end
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd4);

endmodule

[rtl/sha1md_checker.sv]
// Port-level checks for the SHA-1 message digest, bound to the top level.
// Depends only on the ports of sha1_message_digest.
module sha1md_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // A stalled digest word stays offered and unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_word_index))
  else $error("stalled digest word changed or dropped");

  // Only the fifth word of a digest is marked as the last one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd4)))
  else $error("last_word does not match word_index");

  // No message word is taken while a digest is being delivered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
  else $error("input taken during digest output");

  // A digest word that is not the last is followed by the next index.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> ##2
      (out_valid && out_word_index == $past(out_word_index, 3) + 3'd1))
  else $error("digest words out of order");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_digest_word(out_digest_word),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);

[verif/sha1_message_digest_tb.sv]
// Self-checking testbench for sha1_message_digest: streams byte messages in and
// compares every digest word with a SHA-1 predictor kept in a scoreboard class.
// Depends on sha1md_pkg and the sha1_message_digest RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 280;
  localparam int MsgTarget   = 12;
  localparam int QuietFrom   = 230;
  localparam int HoldAfter   = 40;
  localparam int HoldCycles  = 600;
  localparam int DrainCycles = 200;
  localparam int StallLimit  = 5000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  class digest_scoreboard;
    logic [31:0]  hash_state [5];
    logic [31:0]  msg_sched [16];
    logic [5:0]   fill_pos;
    logic [60:0]  msg_len;
    digest_word_t pending_q [$];
    int           errors;
    int           items_noted;

    function new();
      foreach (msg_sched[i]) msg_sched[i] = '0;
      errors      = 0;
      items_noted = 0;
      restart();
    endfunction

    function void restart();
      hash_state[0] = 32'h67452301;
      hash_state[1] = 32'hEFCDAB89;
      hash_state[2] = 32'h98BADCFE;
      hash_state[3] = 32'h10325476;
      hash_state[4] = 32'hC3D2E1F0;
      fill_pos      = '0;
      msg_len       = '0;
    endfunction

    function void run_rounds();
      logic [31:0] a, b, c, d, e, f, k, w, t;
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
        if (r < 16) begin
          w = msg_sched[r];
        end else begin
          w = msg_sched[(r - 3) & 15] ^ msg_sched[(r - 8) & 15] ^
              msg_sched[(r - 14) & 15] ^ msg_sched[r & 15];
          w = {w[30:0], w[31]};
          msg_sched[r & 15] = w;
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = sha1md_pkg::K0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = sha1md_pkg::K1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = sha1md_pkg::K2;
        end else begin
          f = b ^ c ^ d;
          k = sha1md_pkg::K3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + w;
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
    endfunction

    // Bytes shift into the schedule word big-endian; a full block compresses.
    function void absorb_byte(input logic [7:0] value);
      msg_sched[fill_pos[5:2]] = {msg_sched[fill_pos[5:2]][23:0], value};
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0) run_rounds();
    endfunction

    function void note_input(input logic [7:0] data, input logic has_byte,
                             input logic ends);
      logic [63:0] bit_len;
      if (has_byte || ends) items_noted++;
      if (has_byte) begin
        absorb_byte(data);
        msg_len = msg_len + 61'd1;
      end
      if (!ends) return;
      absorb_byte(sha1md_pkg::PadByte);
      while (fill_pos != 6'd56) absorb_byte(8'h00);
      bit_len = {msg_len, 3'b000};
      for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8 * i +: 8]);
      for (int i = 0; i < 5; i++) begin
        pending_q.push_back('{word: hash_state[i], index: 3'(i), last: (i == 4)});
      end
      restart();
    endfunction

    function void check_digest(input logic [31:0] word, input logic [2:0] index,
                               input logic last);
      digest_word_t exp;
      if (pending_q.size() == 0) begin
        $error("digest word %h index %0d arrived with nothing expected", word, index);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (word !== exp.word) begin
        $error("digest_word: expected %h, got %h", exp.word, word);
        errors++;
      end
      if (index !== exp.index) begin
        $error("word_index: expected %0d, got %0d", exp.index, index);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last_word: expected %0b, got %0b", exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte      = '0;
  logic        in_carries_byte   = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall         = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_scoreboard sb = new();
  bit idle_on   = 1'b1;
  int items_sent = 0;
  int msgs_sent  = 0;

  sha1_message_digest i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one word and holds it until the block takes it.
  task automatic send_word(input logic [7:0] data, input logic has_byte,
                           input logic ends);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_carries_byte   <= has_byte;
    in_end_of_message <= ends;
    do @(posedge clk); while (in_stall);
    sb.note_input(data, has_byte, ends);
    if (has_byte || ends) items_sent++;
    if (ends) msgs_sent++;
  endtask

  initial begin : stimulus
    int len;
    bit end_on_byte;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(8'hFF, 1'b0, 1'b0);   // ignored word with stray data
    send_word(8'h00, 1'b0, 1'b1);   // empty message
    send_word(8'hFF, 1'b1, 1'b1);   // single byte carrying the end mark
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);   // "abc"
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);   // end mark on a word without a byte
    send_word(8'hC3, 1'b0, 1'b1);   // empty message right after a message end
    send_word(8'h80, 1'b1, 1'b1);
    send_word(8'h7F, 1'b1, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'hFE, 1'b1, 1'b1);

    while (items_sent < ItemTarget || msgs_sent < MsgTarget) begin
      idle_on = (items_sent < QuietFrom) && ($urandom_range(0, 3) != 0);
      // Mostly short messages; the rest sit around the one/two padding block
      // boundary or span several blocks.
      case ($urandom_range(0, 9)) inside
        [0:5]:   len = $urandom_range(0, 12);
        [6:8]:   len = $urandom_range(55, 64);
        default: len = $urandom_range(65, 130);
      endcase
      // The last message is cut short so the run stays near the item target.
      if (items_sent + len > ItemTarget) begin
        len = (items_sent < ItemTarget) ? ItemTarget - items_sent : 0;
      end
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte) send_word(8'($urandom), 1'b0, 1'b1);
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin : receiver
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_digest(out_digest_word, out_word_index, out_last_word);
      end
      // One long hold lets the digest back up until the input stalls.
      if (!held && sb.items_noted >= HoldAfter) begin
        held       = 1'b1;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
